// ===== rtl/bppg_pkg.sv =====
`timescale 1ns / 1ps
package bppg_pkg;

   // position format
   localparam int POS_FRAC_BITS = 16;
   localparam int POS_INT_BITS  = 24;
   localparam int POS_W         = POS_INT_BITS + POS_FRAC_BITS;
   localparam int STATE_W       = POS_W + 2;
   localparam int DIFF_W        = STATE_W + 1;

   // step and varispeed
   localparam int SPEED_W     = 25;
   localparam int FACTOR_W    = 16;
   localparam int FACTOR_FRAC = 12;
   localparam int PROD_W      = SPEED_W + FACTOR_W;
   localparam int STEP_W      = PROD_W - FACTOR_FRAC;

   // phase
   localparam int SCALE_W     = 34;
   localparam int MAG_W       = 32;
   localparam int PHASE_W     = 17;
   localparam int PHASE_SHIFT = MAG_W - (PHASE_W - 1);
   localparam int MUL_W       = 2 * MAG_W;
   localparam int RATIO_W     = MUL_W - PHASE_SHIFT;
   localparam logic [PHASE_W-1:0] PHASE_ONE = {1'b1, {(PHASE_W - 1){1'b0}}};

   // channels
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = POS_W;
   localparam int RSP_BITS   = POS_W + PHASE_W + 2;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK = OP_W'(0);
   localparam logic [OP_W-1:0] OP_PLAY = OP_W'(1);
   localparam logic [OP_W-1:0] OP_STOP = OP_W'(2);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_STEP  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_POS     = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POS     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_SCALE = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_VARISPEED   = CSR_IDX_W'(5);

   // unity step, one sample per tick
   localparam logic signed [SPEED_W-1:0] SPEED_STEP_RESET = SPEED_W'(1 << POS_FRAC_BITS);

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed_step;
      logic [POS_W-1:0]          start_pos;
      logic [POS_W-1:0]          min_pos;
      logic [POS_W-1:0]          max_pos;
      logic signed [SCALE_W-1:0] phase_scale;
      logic                      varispeed_on;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [STEP_W-1:0] step;
   } step_item_type;

   typedef struct packed {
      logic signed [STATE_W-1:0] pos;
      logic                      active;
      logic                      done;
   } trk_item_type;

endpackage

// ===== rtl/bounded_playback_phase_generator_core.sv =====
`timescale 1ns / 1ps
// path: step input and output, tracker, phase prep and result registers
// throughput: one request per cycle unless results stall; the tracker's position
// add and range compare close the only loop; each stage owns a hand-off register
// reset: synchronous, active high; registers go to their reset values, position
// is cleared, playback is stopped and the pipeline is emptied
module bounded_playback_phase_generator_core import bppg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [FACTOR_W-1:0]   req_tdata,   // [15:0] speed_factor
   input  logic [OP_W-1:0]       req_tuser,   // [1:0] operation
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [39:0] position, [56:40] phase,
                                              // [57] active, [58] done_res, rest zero
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type            cfg_ff, cfg_in;

   logic               s_valid, s_ready;
   step_item_type      s_item;
   logic               t_valid, t_ready;
   trk_item_type       t_item;
   logic [POS_W-1:0]   rsp_position;
   logic [PHASE_W-1:0] rsp_phase;
   logic               rsp_active;
   logic               rsp_done;

   // register writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SPEED_STEP:  cfg_in.speed_step   = csr_data[SPEED_W-1:0];
            CSR_START_POS:   cfg_in.start_pos    = csr_data[POS_W-1:0];
            CSR_MIN_POS:     cfg_in.min_pos      = csr_data[POS_W-1:0];
            CSR_MAX_POS:     cfg_in.max_pos      = csr_data[POS_W-1:0];
            CSR_PHASE_SCALE: cfg_in.phase_scale  = csr_data[SCALE_W-1:0];
            CSR_VARISPEED:   cfg_in.varispeed_on = csr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_step   <= SPEED_STEP_RESET;
         cfg_ff.start_pos    <= '0;
         cfg_ff.min_pos      <= '0;
         cfg_ff.max_pos      <= '0;
         cfg_ff.phase_scale  <= '0;
         cfg_ff.varispeed_on <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register and per-tick step (fixed or varispeed)
   bppg_step u_step (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser),
      .in_factor (req_tdata),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_item  (s_item)
   );

   // play / stop, range check and position advance
   bppg_track u_track (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_item   (s_item),
      .out_valid (t_valid),
      .out_ready (t_ready),
      .out_item  (t_item)
   );

   // normalised phase, two stages, last one is the result register
   bppg_phase u_phase (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (t_valid),
      .in_ready     (t_ready),
      .in_item      (t_item),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_position (rsp_position),
      .out_phase    (rsp_phase),
      .out_active   (rsp_active),
      .out_done     (rsp_done)
   );

   assign rsp_tdata = {(RSP_DATA_W - RSP_BITS)'(0), rsp_done, rsp_active,
                       rsp_phase, rsp_position};

   // done only marks the first idle tick after playback
   a_done_not_active : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_active && rsp_done))
      else $error("done and active both set");

   // an idle result carries zero position and full phase
   a_idle_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_active) |-> (rsp_phase == PHASE_ONE && rsp_position == '0))
      else $error("idle result not in idle form");

   // phase is saturated to one
   a_phase_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_phase <= PHASE_ONE))
      else $error("phase above one");

endmodule

// ===== rtl/bppg_step.sv =====
`timescale 1ns / 1ps
module bppg_step import bppg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [OP_W-1:0]            in_op,
   input  logic signed [FACTOR_W-1:0] in_factor,
   output logic                       out_valid,
   input  logic                       out_ready,
   output step_item_type              out_item
);

   logic                       in_v_ff, in_v_in;
   logic [OP_W-1:0]            op_ff, op_in;
   logic signed [FACTOR_W-1:0] fac_ff, fac_in;
   logic                       out_v_ff, out_v_in;
   step_item_type              item_ff, item_in;

   logic                       out_free;
   logic signed [PROD_W-1:0]   spd_x, fac_x, prod;

   assign out_free = !out_v_ff || out_ready;
   assign in_ready = !in_v_ff || out_free;

   // varispeed product, floor by taking the upper bits
   assign spd_x = PROD_W'(cfg.speed_step);
   assign fac_x = PROD_W'(fac_ff);
   assign prod  = spd_x * fac_x;

   always_comb begin
      in_v_in  = in_ready ? in_valid : in_v_ff;
      op_in    = op_ff;
      fac_in   = fac_ff;
      if (in_ready && in_valid) begin
         op_in  = in_op;
         fac_in = in_factor;
      end
      out_v_in = out_free ? in_v_ff : out_v_ff;
      item_in  = item_ff;
      if (out_free && in_v_ff) begin
         item_in.op = op_ff;
         if (cfg.varispeed_on) begin
            item_in.step = prod[PROD_W-1:FACTOR_FRAC];
         end else begin
            item_in.step = STEP_W'(cfg.speed_step);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
      op_ff   <= op_in;
      fac_ff  <= fac_in;
      item_ff <= item_in;
   end

   assign out_valid = out_v_ff;
   assign out_item  = item_ff;

endmodule

// ===== rtl/bppg_track.sv =====
`timescale 1ns / 1ps
module bppg_track import bppg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  step_item_type in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output trk_item_type  out_item
);

   logic signed [STATE_W-1:0] pos_ff, pos_in;
   logic                      running_ff, running_in;
   logic                      was_active_ff, was_active_in;
   logic                      out_v_ff, out_v_in;
   trk_item_type              item_ff, item_in;

   logic                      take;
   logic                      run_sel;
   logic signed [STATE_W-1:0] pos_sel;
   logic                      in_range;

   assign in_ready = !out_v_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      run_sel = running_ff;
      pos_sel = pos_ff;
      case (in_item.op)
         OP_PLAY: begin
            run_sel = 1'b1;
            pos_sel = STATE_W'(cfg.start_pos);
         end
         OP_STOP: begin
            run_sel = 1'b0;
         end
         default: begin
            run_sel = running_ff;
         end
      endcase
   end

   // non-negative and inside [min, max]
   assign in_range = run_sel && !pos_sel[STATE_W-1]
                     && (pos_sel[STATE_W-2:0] >= (STATE_W - 1)'(cfg.min_pos))
                     && (pos_sel[STATE_W-2:0] <= (STATE_W - 1)'(cfg.max_pos));

   always_comb begin
      pos_in        = pos_ff;
      running_in    = running_ff;
      was_active_in = was_active_ff;
      item_in       = item_ff;
      out_v_in      = in_ready ? in_valid : out_v_ff;
      if (take) begin
         running_in     = in_range;
         was_active_in  = in_range;
         pos_in         = in_range ? pos_sel + STATE_W'(in_item.step) : pos_sel;
         item_in.pos    = pos_sel;
         item_in.active = in_range;
         item_in.done   = was_active_ff && !in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         running_ff    <= 1'b0;
         was_active_ff <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         running_ff    <= running_in;
         was_active_ff <= was_active_in;
         out_v_ff      <= out_v_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = out_v_ff;
   assign out_item  = item_ff;

endmodule

// ===== rtl/bppg_phase.sv =====
`timescale 1ns / 1ps
module bppg_phase import bppg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  trk_item_type       in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [POS_W-1:0]   out_position,
   output logic [PHASE_W-1:0] out_phase,
   output logic               out_active,
   output logic               out_done
);

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             active;
      logic             done;
      logic             zero;
      logic             big;
      logic [MAG_W-1:0] a;
      logic [MAG_W-1:0] b;
   } prep_type;

   logic               prep_v_ff, prep_v_in;
   prep_type           prep_ff, prep_in;
   logic               out_v_ff, out_v_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               active_ff, active_in;
   logic               done_ff, done_in;

   logic                     out_free;
   logic signed [DIFF_W-1:0] diff;
   logic                     d_neg, s_neg;
   logic [DIFF_W-1:0]        d_mag;
   logic [SCALE_W-1:0]       s_mag;
   logic [MUL_W-1:0]         prod;
   logic [RATIO_W-1:0]       ratio;
   logic                     over;

   assign out_free = !out_v_ff || out_ready;
   assign in_ready = !prep_v_ff || out_free;

   // offset from start and sign-magnitude split
   assign diff  = DIFF_W'(in_item.pos) - $signed(DIFF_W'(cfg.start_pos));
   assign d_neg = diff[DIFF_W-1];
   assign s_neg = cfg.phase_scale[SCALE_W-1];
   assign d_mag = d_neg ? -diff : diff;
   assign s_mag = s_neg ? -cfg.phase_scale : cfg.phase_scale;

   // second stage multiply, Q16 result with saturation
   assign prod  = MUL_W'(prep_ff.a) * MUL_W'(prep_ff.b);
   assign ratio = prod[MUL_W-1:PHASE_SHIFT];
   assign over  = ratio > RATIO_W'(PHASE_ONE);

   always_comb begin
      prep_v_in = in_ready ? in_valid : prep_v_ff;
      prep_in   = prep_ff;
      if (in_ready && in_valid) begin
         prep_in.pos    = in_item.pos[POS_W-1:0];
         prep_in.active = in_item.active;
         prep_in.done   = in_item.done;
         prep_in.zero   = (diff == '0) || (cfg.phase_scale == '0) || (d_neg != s_neg);
         prep_in.big    = (d_mag[DIFF_W-1:MAG_W] != '0) || (s_mag[SCALE_W-1:MAG_W] != '0);
         prep_in.a      = d_mag[MAG_W-1:0];
         prep_in.b      = s_mag[MAG_W-1:0];
      end
   end

   always_comb begin
      out_v_in    = out_free ? prep_v_ff : out_v_ff;
      position_in = position_ff;
      phase_in    = phase_ff;
      active_in   = active_ff;
      done_in     = done_ff;
      if (out_free && prep_v_ff) begin
         active_in   = prep_ff.active;
         done_in     = prep_ff.done;
         position_in = prep_ff.active ? prep_ff.pos : '0;
         if (!prep_ff.active || (!prep_ff.zero && (prep_ff.big || over))) begin
            phase_in = PHASE_ONE;
         end else if (prep_ff.zero) begin
            phase_in = '0;
         end else begin
            phase_in = ratio[PHASE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         prep_v_ff <= prep_v_in;
         out_v_ff  <= out_v_in;
      end
      prep_ff     <= prep_in;
      position_ff <= position_in;
      phase_ff    <= phase_in;
      active_ff   <= active_in;
      done_ff     <= done_in;
   end

   assign out_valid    = out_v_ff;
   assign out_position = position_ff;
   assign out_phase    = phase_ff;
   assign out_active   = active_ff;
   assign out_done     = done_ff;

endmodule

// ===== tb/bounded_playback_phase_generator_core_tb.sv =====
`timescale 1ns / 1ps

// one result as it sits in rsp_tdata, highest field first
typedef struct packed {
   logic                         done_res;
   logic                         active;
   logic [bppg_pkg::PHASE_W-1:0] phase;
   logic [bppg_pkg::POS_W-1:0]   position;
} playback_result_type;

class playback_scoreboard;
   // register copy
   logic signed [bppg_pkg::SPEED_W-1:0] speed_step;
   logic [bppg_pkg::POS_W-1:0]          start_pos;
   logic [bppg_pkg::POS_W-1:0]          min_pos;
   logic [bppg_pkg::POS_W-1:0]          max_pos;
   logic signed [bppg_pkg::SCALE_W-1:0] phase_scale;
   logic                                varispeed_on;
   // playback state
   logic signed [bppg_pkg::STATE_W-1:0] play_pos;
   logic                                running;
   logic                                was_active;

   playback_result_type expected_q[$];
   int errors;
   int checked;
   int active_seen;
   int done_seen;
   int saturated_seen;

   function new();
      speed_step     = bppg_pkg::SPEED_STEP_RESET;
      start_pos      = '0;
      min_pos        = '0;
      max_pos        = '0;
      phase_scale    = '0;
      varispeed_on   = 1'b0;
      play_pos       = '0;
      running        = 1'b0;
      was_active     = 1'b0;
      errors         = 0;
      checked        = 0;
      active_seen    = 0;
      done_seen      = 0;
      saturated_seen = 0;
   endfunction

   task report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("[%0t] mismatch, %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   function void write_reg(logic [bppg_pkg::CSR_IDX_W-1:0] index,
                           logic [bppg_pkg::CSR_DATA_W-1:0] data);
      case (index)
         bppg_pkg::CSR_SPEED_STEP:  speed_step   = data[bppg_pkg::SPEED_W-1:0];
         bppg_pkg::CSR_START_POS:   start_pos    = data[bppg_pkg::POS_W-1:0];
         bppg_pkg::CSR_MIN_POS:     min_pos      = data[bppg_pkg::POS_W-1:0];
         bppg_pkg::CSR_MAX_POS:     max_pos      = data[bppg_pkg::POS_W-1:0];
         bppg_pkg::CSR_PHASE_SCALE: phase_scale  = data[bppg_pkg::SCALE_W-1:0];
         bppg_pkg::CSR_VARISPEED:   varispeed_on = data[0];
         default: ;
      endcase
   endfunction

   // (pos - start) * scale in Q16, magnitudes truncated, clamped to 0..1
   function logic [bppg_pkg::PHASE_W-1:0] progress_of(longint pos);
      longint d;
      longint s;
      longint unsigned a;
      longint unsigned b;
      longint unsigned r;
      d = pos - longint'(start_pos);
      s = longint'(phase_scale);
      if (d == 0 || s == 0)
         return '0;
      if ((d < 0) != (s < 0))
         return '0;
      a = (d < 0) ? -d : d;
      b = (s < 0) ? -s : s;
      if (a >= 64'd4294967296 || b >= 64'd4294967296)
         return bppg_pkg::PHASE_ONE;
      r = (a * b) >> bppg_pkg::PHASE_SHIFT;
      if (r > longint'(bppg_pkg::PHASE_ONE))
         return bppg_pkg::PHASE_ONE;
      return r[bppg_pkg::PHASE_W-1:0];
   endfunction

   function void note_request(logic [bppg_pkg::OP_W-1:0] op,
                              logic signed [bppg_pkg::FACTOR_W-1:0] factor);
      playback_result_type res;
      longint cur;
      longint stp;
      res = '0;
      res.phase = bppg_pkg::PHASE_ONE;
      if (op == bppg_pkg::OP_PLAY) begin
         play_pos = {2'b00, start_pos};
         running  = 1'b1;
      end else if (op == bppg_pkg::OP_STOP) begin
         running = 1'b0;
      end
      cur = longint'(play_pos);
      if (running && cur >= 0 && cur >= longint'(min_pos) && cur <= longint'(max_pos)) begin
         res.active   = 1'b1;
         res.position = cur[bppg_pkg::POS_W-1:0];
         res.phase    = progress_of(cur);
         stp = longint'(speed_step);
         if (varispeed_on)
            stp = (longint'(speed_step) * longint'(factor)) >>> bppg_pkg::FACTOR_FRAC;
         play_pos = bppg_pkg::STATE_W'(cur + stp);
      end else begin
         running = 1'b0;
      end
      res.done_res = was_active && !res.active;
      was_active   = res.active;
      if (res.active)
         active_seen++;
      if (res.done_res)
         done_seen++;
      if (res.active && res.phase == bppg_pkg::PHASE_ONE)
         saturated_seen++;
      expected_q.push_back(res);
   endfunction

   task check_result(logic [bppg_pkg::RSP_DATA_W-1:0] data);
      playback_result_type got;
      playback_result_type want;
      got = data[bppg_pkg::RSP_BITS-1:0];
      if (expected_q.size() == 0) begin
         report_mismatch("result with nothing outstanding", data, 0);
         return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.position != want.position)
         report_mismatch("position", got.position, want.position);
      if (got.phase != want.phase)
         report_mismatch("phase", got.phase, want.phase);
      if (got.active != want.active)
         report_mismatch("active", got.active, want.active);
      if (got.done_res != want.done_res)
         report_mismatch("done_res", got.done_res, want.done_res);
   endtask
endclass

module bounded_playback_phase_generator_core_tb;
   import bppg_pkg::*;

   // spare operation code, behaves as a plain tick
   localparam logic [OP_W-1:0] OP_SPARE = OP_W'(3);

   localparam longint unsigned POS_TOP   = (64'd1 << POS_W) - 1;
   localparam longint          STEP_TOP  = (64'sd1 << (SPEED_W - 1)) - 1;
   localparam longint          SCALE_TOP = 64'sd1 << MAG_W;
   localparam int RAND_PHASES   = 10;
   localparam int PHASE_ITEMS   = 105;
   localparam int HOLD_CYCLES   = 150;
   localparam int SETTLE_CYCLES = 8;
   localparam int TIMEOUT_NS    = 4_000_000;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [FACTOR_W-1:0]   req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   playback_scoreboard sb = new();

   int send_pct   = 0;
   int stall_pct  = 0;
   int hold_left  = 0;
   bit hold_request = 1'b0;
   int settings_written = 0;

   bounded_playback_phase_generator_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // handshake monitor, feeds the predictor and the checker
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_data);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
      end
   end

   task automatic set_idle(idle_mode_type mode);
      send_pct  = (mode == IDLE_SEND) ? 71 : (mode == IDLE_BOTH) ? 14 : 0;
      stall_pct = (mode == IDLE_RECV) ? 71 : (mode == IDLE_BOTH) ? 14 : 0;
   endtask

   // one request, with a random gap in front; valid stays high afterwards
   task automatic send_req(logic [OP_W-1:0] op, logic [FACTOR_W-1:0] factor);
      while ($urandom_range(0, 99) < send_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= factor;
      do @(posedge clock); while (!req_tready);
   endtask

   // all results in, then an idle wait for the pipeline to empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(longint stp, longint unsigned start, longint unsigned lo,
                                longint unsigned hi, longint scale, bit vari);
      logic [CSR_DATA_W-1:0] vals [6];
      int i;
      vals[CSR_SPEED_STEP]  = CSR_DATA_W'(stp);
      vals[CSR_START_POS]   = CSR_DATA_W'(start);
      vals[CSR_MIN_POS]     = CSR_DATA_W'(lo);
      vals[CSR_MAX_POS]     = CSR_DATA_W'(hi);
      vals[CSR_PHASE_SCALE] = CSR_DATA_W'(scale);
      vals[CSR_VARISPEED]   = CSR_DATA_W'(vari);
      for (i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   task automatic directed_checks();
      // reset setting: a one-point range at zero
      send_req(OP_TICK, 16'h0000);
      send_req(OP_PLAY, 16'hFFFF);
      send_req(OP_TICK, 16'h0000);
      send_req(OP_SPARE, 16'h5555);
      settle();
      // forward unity step through a small window, runs off the top
      write_setting(64'sd65536, 'h50000, 'h30000, 'h90000, 64'sd10923, 1'b0);
      send_req(OP_PLAY, 16'h8000);
      repeat (5) send_req(OP_TICK, 16'h7FFF);
      send_req(OP_SPARE, 16'hAAAA);
      settle();
      // most negative step from the top of the buffer, negative scale of magnitude 2^32
      write_setting(-STEP_TOP - 1, POS_TOP, 0, POS_TOP, -SCALE_TOP, 1'b0);
      send_req(OP_PLAY, 16'h0000);
      send_req(OP_TICK, 16'h0000);
      send_req(OP_STOP, 16'h0000);
      settle();
      // largest step, varispeed at both factor extremes, falls below zero
      write_setting(STEP_TOP, 0, 0, POS_TOP, SCALE_TOP, 1'b1);
      send_req(OP_PLAY, 16'h7FFF);
      send_req(OP_TICK, 16'h8000);
      send_req(OP_TICK, 16'h1000);
      send_req(OP_TICK, 16'h0000);
      settle();
      // zero step holds the position and stays active
      write_setting(0, 'h20000, 'h10000, 'h30000, 64'sd65536, 1'b0);
      send_req(OP_PLAY, 16'h1234);
      repeat (2) send_req(OP_TICK, 16'h4321);
      settle();
      // start beyond the window: play disarms at once, done only after an active tick
      write_setting(0, 'h40000, 'h10000, 'h30000, 64'sd65536, 1'b0);
      send_req(OP_PLAY, 16'h0000);
      send_req(OP_PLAY, 16'h0000);
      send_req(OP_STOP, 16'h0000);
      settle();
   endtask

   task automatic pick_setting();
      longint unsigned span;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned start;
      longint stp;
      longint scale;
      case ($urandom_range(0, 9))
         0:       span = POS_TOP;
         1, 2:    span = 64'($urandom_range(1, 65535));
         default: span = longint'($urandom_range(1, 40)) * 65536 + $urandom_range(0, 65535);
      endcase
      lo    = (span == POS_TOP) ? 0 : {$urandom_range(0, 255), $urandom} % (POS_TOP - span + 1);
      hi    = lo + span;
      start = lo + ({$urandom, $urandom} % (span + 1));
      if ($urandom_range(0, 9) == 0) begin
         if (lo > 65536)
            start = lo - $urandom_range(1, 65536);
         else if (hi < POS_TOP - 65536)
            start = hi + $urandom_range(1, 65536);
      end
      stp = longint'(span / $urandom_range(3, 40)) + 1;
      if (stp > STEP_TOP)
         stp = STEP_TOP;
      if ($urandom_range(0, 1))
         stp = -stp;
      case ($urandom_range(0, 19))
         0: stp = 0;
         1: stp = STEP_TOP;
         2: stp = -STEP_TOP - 1;
         default: ;
      endcase
      // scale follows the direction of travel, now and then the other way
      scale = longint'(64'd4294967296 / span);
      if (stp < 0)
         scale = -scale;
      if ($urandom_range(0, 9) == 0)
         scale = -scale;
      case ($urandom_range(0, 19))
         0: scale = SCALE_TOP;
         1: scale = -SCALE_TOP;
         2: scale = 0;
         default: ;
      endcase
      write_setting(stp, start, lo, hi, scale, 1'($urandom_range(0, 1)));
   endtask

   // mostly ticks inside runs that start with a play; stops and spare codes mixed in
   task automatic random_playback(int count, bit squeeze);
      logic [OP_W-1:0]            op;
      logic signed [FACTOR_W-1:0] factor;
      int pick;
      int i;
      for (i = 0; i < count; i++) begin
         if (squeeze && i == 10)
            hold_request = 1'b1;
         pick = $urandom_range(0, 99);
         if (i == 0 || pick < 6)
            op = OP_PLAY;
         else if (pick < 9)
            op = OP_STOP;
         else if (pick < 12)
            op = OP_SPARE;
         else
            op = OP_TICK;
         if (sb.varispeed_on && $urandom_range(0, 9) < 7) begin
            factor = FACTOR_W'($urandom_range(2048, 8192));
            if ($urandom_range(0, 4) == 0)
               factor = -factor;
         end else begin
            factor = FACTOR_W'($urandom);
         end
         send_req(op, factor);
      end
   endtask

   initial begin
      int ph;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= OP_TICK;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_SPEED_STEP;
      csr_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_idle(IDLE_NONE);
      directed_checks();

      // idling mode cycles per phase; phase 4 runs flat out with the long hold-off
      for (ph = 0; ph < RAND_PHASES; ph++) begin
         set_idle(idle_mode_type'(ph % 4));
         pick_setting();
         random_playback(PHASE_ITEMS, ph == 4);
         settle();
      end

      $display("checked %0d results over %0d register settings", sb.checked, settings_written);
      $display("active ticks %0d, done pulses %0d, saturated phases %0d",
               sb.active_seen, sb.done_seen, sb.saturated_seen);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("run stopped at the time limit, %0d results still outstanding",
               sb.expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== bounded_playback_phase_generator_core.f =====
rtl/bppg_pkg.sv
rtl/bppg_step.sv
rtl/bppg_track.sv
rtl/bppg_phase.sv
rtl/bounded_playback_phase_generator_core.sv
tb/bounded_playback_phase_generator_core_tb.sv
